[rtl/jss_pkg.sv]
`default_nettype none

package jss_pkg;

  localparam int SLOTS_DEF = 4;

  localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY  = 32'hedb8_8320;
  localparam logic [31:0] HALF_DIST = 32'h8000_0000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MAGIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_MAGIC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT  = 2'd2;

  // word positions inside one record
  localparam logic [2:0] WP_FORMAT    = 3'd0;
  localparam logic [2:0] WP_SEQ       = 3'd1;
  localparam logic [2:0] WP_COUNT     = 3'd2;
  localparam logic [2:0] WP_FAULT     = 3'd3;
  localparam logic [2:0] WP_SEQ_INV   = 3'd4;
  localparam logic [2:0] WP_COUNT_INV = 3'd5;
  localparam logic [2:0] WP_CRC       = 3'd6;
  localparam logic [2:0] WP_COMMIT    = 3'd7;

  typedef struct packed {
    logic [31:0] word;
    logic        read_ok;
    logic        scan_start;
  } jss_in_t;

  typedef struct packed {
    logic [1:0]  active_slot;
    logic [31:0] newest_sequence;
    logic [31:0] newest_count;
    logic        fault;
    logic        found_valid;
    logic        store_blank;
    logic        scan_err;
  } jss_out_t;

  typedef logic [31:0][31:0] crc_mat_t;

  // Column j is the 32-shift CRC response to input bit j alone; the update
  // is linear, so a full word is the XOR of the columns of its set bits.
  function automatic crc_mat_t crc_build();
    crc_mat_t    m;
    logic [31:0] c;
    for (int j = 0; j < 32; j++) begin
      c = 32'(1) << j;
      for (int i = 0; i < 32; i++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      m[j] = c;
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_COLS = crc_build();

  function automatic logic [31:0] crc_apply(input logic [31:0] x);
    logic [31:0] r;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      if (x[j]) r = r ^ CRC_COLS[j];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/journal_slot_scan.sv]
`default_nettype none

// Path: a word is registered in the input register on transfer and folded into the
// scan state when that register advances; the result of the last word of the last slot
// is then loaded into the output register, which raises out_valid.
// Throughput: one word per cycle, with a combinational CRC-32 update and checks;
// a held result stalls input only while the next scan's last word waits.
// Reset (synchronous, rst_n low) restores the configuration and scan state.
module journal_slot_scan #(
  parameter int SLOTS = jss_pkg::SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire jss_pkg::jss_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output jss_pkg::jss_out_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic [jss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                cfg_wdata
);
  import jss_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // configuration
  logic [31:0] format_magic_r, commit_magic_r, count_limit_r;

  // input register
  logic    s0_valid_r;
  jss_in_t s0_data_r;

  // scan state
  logic [2:0]        wpos_r, wpos_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       rec_seq_r, rec_seq_nxt;
  logic [31:0]       rec_cnt_r, rec_cnt_nxt;
  logic              rec_fault_r, rec_fault_nxt;
  logic              rec_good_r, rec_good_nxt;
  logic              best_valid_r, best_valid_nxt;
  logic [SLOT_W-1:0] best_slot_r, best_slot_nxt;
  logic [31:0]       best_seq_r, best_seq_nxt;
  logic [31:0]       best_cnt_r, best_cnt_nxt;
  logic              best_fault_r, best_fault_nxt;
  logic              err_r, err_nxt;
  logic              allz_r, allz_nxt;

  // output register
  logic     out_valid_r;
  jss_out_t out_data_r;
  jss_out_t result;

  logic produce, s0_adv, in_xfer;

  // current view of the state, with a scan start folded in
  logic [2:0]        c_wpos;
  logic [SLOT_W-1:0] c_slot;
  logic [31:0]       c_crc, c_seq, c_cnt, c_bseq, c_bcnt;
  logic              c_fault, c_good, c_bvalid, c_bfault, c_err, c_allz;
  logic [SLOT_W-1:0] c_bslot;

  logic [31:0] w, crc_upd, delta;
  logic        good, end_rec, take, conflict;
  logic        n_bvalid, n_bfault;
  logic [SLOT_W-1:0] n_bslot;
  logic [31:0] n_bseq, n_bcnt;

  always_comb begin
    c_wpos   = s0_data_r.scan_start ? WP_FORMAT : wpos_r;
    c_slot   = s0_data_r.scan_start ? '0 : slot_r;
    c_crc    = s0_data_r.scan_start ? CRC_INIT : crc_r;
    c_seq    = s0_data_r.scan_start ? '0 : rec_seq_r;
    c_cnt    = s0_data_r.scan_start ? '0 : rec_cnt_r;
    c_fault  = s0_data_r.scan_start ? 1'b0 : rec_fault_r;
    c_good   = s0_data_r.scan_start ? 1'b1 : rec_good_r;
    c_bvalid = s0_data_r.scan_start ? 1'b0 : best_valid_r;
    c_bslot  = s0_data_r.scan_start ? LAST_SLOT : best_slot_r;
    c_bseq   = s0_data_r.scan_start ? '0 : best_seq_r;
    c_bcnt   = s0_data_r.scan_start ? '0 : best_cnt_r;
    c_bfault = s0_data_r.scan_start ? 1'b0 : best_fault_r;
    c_err    = s0_data_r.scan_start ? 1'b0 : err_r;
    c_allz   = s0_data_r.scan_start ? 1'b1 : allz_r;

    w = s0_data_r.read_ok ? s0_data_r.word : '0;
    crc_upd = crc_apply(c_crc ^ w);

    good          = c_good & s0_data_r.read_ok;
    err_nxt       = c_err | ~s0_data_r.read_ok;
    allz_nxt      = c_allz & (w == '0);
    crc_nxt       = crc_upd;
    rec_seq_nxt   = c_seq;
    rec_cnt_nxt   = c_cnt;
    rec_fault_nxt = c_fault;

    case (c_wpos)
      WP_FORMAT: begin
        if (w != format_magic_r) good = 1'b0;
      end
      WP_SEQ: begin
        rec_seq_nxt = w;
      end
      WP_COUNT: begin
        rec_cnt_nxt = w;
        if (w > count_limit_r) good = 1'b0;
      end
      WP_FAULT: begin
        rec_fault_nxt = (w != '0);
        if (w > 32'd1) good = 1'b0;
      end
      WP_SEQ_INV: begin
        if (w != ~c_seq) good = 1'b0;
      end
      WP_COUNT_INV: begin
        if (w != ~c_cnt) good = 1'b0;
      end
      WP_CRC: begin
        crc_nxt = c_crc;
        if (w != ~c_crc) good = 1'b0;
      end
      default: begin
        crc_nxt = c_crc;
        if (w != commit_magic_r) good = 1'b0;
      end
    endcase

    end_rec = (c_wpos == WP_COMMIT);

    // newest record by serial-number order on the sequence
    delta    = c_seq - c_bseq;
    conflict = c_bvalid && (((delta == '0) && ((c_cnt != c_bcnt) || (c_fault != c_bfault)))
                            || (delta == HALF_DIST));
    take     = !c_bvalid || ((delta != '0) && (delta < HALF_DIST));
    n_bvalid = c_bvalid;
    n_bslot  = c_bslot;
    n_bseq   = c_bseq;
    n_bcnt   = c_bcnt;
    n_bfault = c_bfault;
    if (end_rec && good) begin
      if (conflict) err_nxt = 1'b1;
      if (take) begin
        n_bvalid = 1'b1;
        n_bslot  = c_slot;
        n_bseq   = c_seq;
        n_bcnt   = c_cnt;
        n_bfault = c_fault;
      end
    end

    produce = end_rec && (c_slot == LAST_SLOT);

    result.active_slot     = 2'(n_bslot);
    result.newest_sequence = n_bvalid ? n_bseq : '0;
    result.newest_count    = n_bvalid ? n_bcnt : '0;
    result.fault           = n_bfault | err_nxt | ~n_bvalid;
    result.found_valid     = n_bvalid;
    result.store_blank     = allz_nxt;
    result.scan_err        = err_nxt;

    wpos_nxt       = c_wpos + 3'd1;
    slot_nxt       = c_slot;
    rec_good_nxt   = good;
    best_valid_nxt = n_bvalid;
    best_slot_nxt  = n_bslot;
    best_seq_nxt   = n_bseq;
    best_cnt_nxt   = n_bcnt;
    best_fault_nxt = n_bfault;
    if (end_rec) begin
      crc_nxt      = CRC_INIT;
      rec_good_nxt = 1'b1;
      slot_nxt     = c_slot + SLOT_W'(1);
    end
    if (produce) begin
      // scan done: back to the idle scan state
      slot_nxt       = '0;
      rec_seq_nxt    = '0;
      rec_cnt_nxt    = '0;
      rec_fault_nxt  = 1'b0;
      best_valid_nxt = 1'b0;
      best_slot_nxt  = LAST_SLOT;
      best_seq_nxt   = '0;
      best_cnt_nxt   = '0;
      best_fault_nxt = 1'b0;
      err_nxt        = 1'b0;
      allz_nxt       = 1'b1;
    end
  end

  assign s0_adv   = s0_valid_r && (!produce || !out_valid_r || !out_stall);
  assign in_stall = s0_valid_r && !s0_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_magic_r <= '0;
      commit_magic_r <= '0;
      count_limit_r  <= CRC_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT_MAGIC: format_magic_r <= cfg_wdata;
        CFG_COMMIT_MAGIC: commit_magic_r <= cfg_wdata;
        CFG_COUNT_LIMIT:  count_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s0_valid_r <= 1'b1;
    end else if (s0_adv) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s0_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r       <= WP_FORMAT;
      slot_r       <= '0;
      crc_r        <= CRC_INIT;
      rec_seq_r    <= '0;
      rec_cnt_r    <= '0;
      rec_fault_r  <= 1'b0;
      rec_good_r   <= 1'b1;
      best_valid_r <= 1'b0;
      best_slot_r  <= LAST_SLOT;
      best_seq_r   <= '0;
      best_cnt_r   <= '0;
      best_fault_r <= 1'b0;
      err_r        <= 1'b0;
      allz_r       <= 1'b1;
    end else if (s0_adv) begin
      wpos_r       <= wpos_nxt;
      slot_r       <= slot_nxt;
      crc_r        <= crc_nxt;
      rec_seq_r    <= rec_seq_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
      rec_fault_r  <= rec_fault_nxt;
      rec_good_r   <= rec_good_nxt;
      best_valid_r <= best_valid_nxt;
      best_slot_r  <= best_slot_nxt;
      best_seq_r   <= best_seq_nxt;
      best_cnt_r   <= best_cnt_nxt;
      best_fault_r <= best_fault_nxt;
      err_r        <= err_nxt;
      allz_r       <= allz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv && produce) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && produce) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
